[design/assert_macros.svh]
// Assertion macros used by the box walker RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that an expression holds at every clock edge outside reset.
`define CHK_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Checks that a consequence holds in the cycle after its antecedent.
`define CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[design/iso_mbw_pkg.sv]
// Types and constants of the ISO media box walker.
`timescale 1ns / 1ps

package iso_mbw_pkg;

  localparam int unsigned OFFSET_BITS_DEF = 64;

  // Stream widths
  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_FIELD_W = 2 + 64 + 64 + 32 + 64;
  localparam int unsigned OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

  // Box header layout
  localparam logic [4:0]  HDR_SHORT  = 5'd8;
  localparam logic [4:0]  HDR_LONG   = 5'd16;
  localparam logic [63:0] SIZE_LARGE = 64'd1;

  // Result queue
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_INCOMPLETE = 2'd1,
    ST_ZERO_SIZE  = 2'd2,
    ST_MALFORMED  = 2'd3
  } status_t;

  typedef enum logic {
    KIND_BOX   = 1'b0,
    KIND_FINAL = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    status_t     status;
    logic [63:0] offset;
    logic [63:0] length;
    logic [31:0] btype;
    logic [63:0] expected;
    logic        last;
  } result_t;

endpackage

[design/iso_media_box_walker_top.sv]
// Top level of the ISO media box walker: byte input stage, header walk and result queue.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// The walker takes an MP4/MOV file one byte per request on the in_ channel, with in_tlast
// on the final byte, and follows the chain of top-level boxes. For every complete box header
// it sends a box report (out_tuser low) carrying the start offset, decoded size and type; on
// the final byte it sends a final status (out_tuser high, out_tlast high) with the overall
// status and the end offset of the last box walked, or zero if the walk stopped. A declared
// size of zero or a size smaller than its own header stops the walk, and later bytes of that
// file are ignored. After the final byte all walking state returns to its reset value, ready
// for the next file. The block sustains one byte per clock while the result queue has room:
// a byte taken into the input register is processed against the walking state while it sits
// there, and its results enter a four-entry result queue at the edge where it moves on, a box
// report ahead of the final status of the same byte. A byte moves on only while the queue has
// room for two results, so the input stalls only if the result side is held back. Offsets
// saturate at 2^OFFSET_BITS - 1. No clearing pass is needed after reset.
module iso_media_box_walker_top #(
  parameter int unsigned OFFSET_BITS = iso_mbw_pkg::OFFSET_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [iso_mbw_pkg::IN_TDATA_W-1:0] in_tdata,   // [7:0] byte_value
  input  logic                               in_tlast,   // end_of_file
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [1:0] status, [65:2] box_offset, [129:66] box_length, [161:130] box_fourcc,
  // [225:162] expected_size, upper bits zero
  output logic [iso_mbw_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                               out_tuser,  // report_kind
  output logic                               out_tlast   // last_result
);

  import iso_mbw_pkg::*;

  localparam logic [OFFSET_BITS-1:0] OFS_MAX = '1;

  // Saturating offset sum: the result never exceeds 2^OFFSET_BITS - 1.
  function automatic logic [OFFSET_BITS-1:0] sat_add(input logic [OFFSET_BITS-1:0] a,
                                                     input logic [63:0] b);
    logic [64:0] sum;
    sum = {1'b0, 64'(a)} + {1'b0, b};
    if (sum[64:OFFSET_BITS] != '0) begin
      return OFS_MAX;
    end
    return sum[OFFSET_BITS-1:0];
  endfunction

  // Input register.
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_eof_r;
  logic       s1_fire;

  // Walking state.
  logic [OFFSET_BITS-1:0] pos_r, pos_nxt;
  logic [OFFSET_BITS-1:0] box_start_r, box_start_nxt;
  logic [OFFSET_BITS-1:0] nbs_r, nbs_nxt;
  logic [4:0]             hdr_idx_r, hdr_idx_nxt;
  logic [63:0]            size_r, size_nxt;
  logic [31:0]            type_r, type_nxt;
  status_t                stat_r, stat_nxt;
  logic                   stopped_r, stopped_nxt;

  // Results of the byte in process.
  logic                   rep_valid;
  logic                   fin_valid;
  result_t                rep_res;
  result_t                fin_res;
  logic [4:0]             idx_inc;
  logic [4:0]             hdr_len;
  logic [OFFSET_BITS-1:0] file_len;

  // Result queue.
  result_t           q_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;
  logic              push0;
  logic              push1;
  result_t           push0_res;
  logic              pop;

  // A byte moves on only when the queue can take both results it may cause.
  assign s1_fire   = s1_valid_r && (cnt_r <= QCNT_W'(QDEPTH - 2));
  assign in_tready = !s1_valid_r || s1_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_byte_r <= in_tdata[7:0];
      s1_eof_r  <= in_tlast;
    end
  end

  // Header walk for one byte. The body of a box is skipped by waiting until the stream
  // position reaches the start of the next box.
  always_comb begin
    pos_nxt       = pos_r;
    box_start_nxt = box_start_r;
    nbs_nxt       = nbs_r;
    hdr_idx_nxt   = hdr_idx_r;
    size_nxt      = size_r;
    type_nxt      = type_r;
    stat_nxt      = stat_r;
    stopped_nxt   = stopped_r;
    rep_valid     = 1'b0;
    fin_valid     = 1'b0;
    idx_inc       = hdr_idx_r + 5'd1;
    hdr_len       = '0;
    file_len      = sat_add(pos_r, 64'd1);

    rep_res = '{kind: KIND_BOX, status: ST_OK, offset: '0, length: '0, btype: '0,
                expected: '0, last: 1'b0};
    fin_res = '{kind: KIND_FINAL, status: ST_OK, offset: '0, length: '0, btype: '0,
                expected: '0, last: 1'b1};

    if (s1_fire) begin
      if (!stopped_r && ((hdr_idx_r != '0) || (pos_r == nbs_r))) begin
        if (hdr_idx_r == '0) begin
          box_start_nxt = pos_r;
          size_nxt      = '0;
          type_nxt      = '0;
        end
        if (hdr_idx_r < 5'd4) begin
          size_nxt = {size_nxt[55:0], s1_byte_r};
        end else if (hdr_idx_r < HDR_SHORT) begin
          type_nxt = {type_nxt[23:0], s1_byte_r};
        end else if (hdr_idx_r == HDR_SHORT) begin
          size_nxt = {56'd0, s1_byte_r};
        end else begin
          size_nxt = {size_nxt[55:0], s1_byte_r};
        end
        hdr_idx_nxt = idx_inc;

        if (idx_inc == HDR_SHORT) begin
          if (size_nxt == '0) begin
            stopped_nxt = 1'b1;
            stat_nxt    = ST_ZERO_SIZE;
            hdr_idx_nxt = '0;
          end else if (size_nxt != SIZE_LARGE) begin
            hdr_len = HDR_SHORT;
          end
        end else if (idx_inc >= HDR_LONG) begin
          hdr_len = HDR_LONG;
        end

        if (hdr_len != '0) begin
          hdr_idx_nxt = '0;
          if (size_nxt < 64'(hdr_len)) begin
            stopped_nxt = 1'b1;
            stat_nxt    = ST_MALFORMED;
          end else begin
            rep_valid      = 1'b1;
            rep_res.offset = 64'(box_start_nxt);
            rep_res.length = size_nxt;
            rep_res.btype  = type_nxt;
            nbs_nxt        = sat_add(box_start_nxt, size_nxt);
          end
        end
      end

      if (s1_eof_r) begin
        fin_valid = 1'b1;
        if (stopped_nxt) begin
          fin_res.status = stat_nxt;
        end else if (hdr_idx_nxt >= HDR_SHORT) begin
          // The file ends inside a 64-bit size.
          fin_res.status   = ST_INCOMPLETE;
          fin_res.expected = 64'(nbs_nxt);
        end else if (hdr_idx_nxt != '0) begin
          // A short tail inside a plain header is accepted.
          fin_res.expected = 64'(nbs_nxt);
        end else begin
          fin_res.status   = (nbs_nxt > file_len) ? ST_INCOMPLETE : ST_OK;
          fin_res.expected = 64'(nbs_nxt);
        end
        // A new file starts from the reset state.
        pos_nxt       = '0;
        box_start_nxt = '0;
        nbs_nxt       = '0;
        hdr_idx_nxt   = '0;
        size_nxt      = '0;
        type_nxt      = '0;
        stat_nxt      = ST_OK;
        stopped_nxt   = 1'b0;
      end else begin
        pos_nxt = file_len;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      box_start_r <= '0;
      nbs_r       <= '0;
      hdr_idx_r   <= '0;
      size_r      <= '0;
      type_r      <= '0;
      stat_r      <= ST_OK;
      stopped_r   <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      box_start_r <= box_start_nxt;
      nbs_r       <= nbs_nxt;
      hdr_idx_r   <= hdr_idx_nxt;
      size_r      <= size_nxt;
      type_r      <= type_nxt;
      stat_r      <= stat_nxt;
      stopped_r   <= stopped_nxt;
    end
  end

  // A box report always goes ahead of the final status of the same byte.
  assign push0     = rep_valid || fin_valid;
  assign push1     = rep_valid && fin_valid;
  assign push0_res = rep_valid ? rep_res : fin_res;
  assign pop       = out_tvalid && out_tready;

  always_ff @(posedge clk) begin
    if (push0) begin
      q_r[wr_ptr_r] <= push0_res;
    end
    if (push1) begin
      q_r[wr_ptr_r + QPTR_W'(1)] <= fin_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + QPTR_W'(push0) + QPTR_W'(push1);
      rd_ptr_r <= rd_ptr_r + QPTR_W'(pop);
      cnt_r    <= cnt_r + QCNT_W'(push0) + QCNT_W'(push1) - QCNT_W'(pop);
    end
  end

  assign out_tvalid = (cnt_r != '0);
  assign out_tuser  = q_r[rd_ptr_r].kind;
  assign out_tlast  = q_r[rd_ptr_r].last;
  assign out_tdata  = {(OUT_TDATA_W - OUT_FIELD_W)'(0),
                       q_r[rd_ptr_r].expected,
                       q_r[rd_ptr_r].btype,
                       q_r[rd_ptr_r].length,
                       q_r[rd_ptr_r].offset,
                       q_r[rd_ptr_r].status};

  `CHK_ALWAYS(a_queue_bound, cnt_r <= QCNT_W'(QDEPTH), "result queue overfilled")
  `CHK_ALWAYS(a_hdr_idx_range, hdr_idx_r < HDR_LONG, "header index out of range")
  `CHK_ALWAYS(a_stop_idle, !stopped_r || (hdr_idx_r == '0), "header walk while stopped")
  `CHK_ALWAYS(a_final_last, !(out_tvalid && out_tuser) || out_tlast, "final status not last")
  `CHK_NEXT(a_eof_clear, s1_fire && s1_eof_r,
            (pos_r == '0) && (nbs_r == '0) && !stopped_r && (hdr_idx_r == '0),
            "state not cleared after end of file")

endmodule

[dv/tb_iso_media_box_walker_top.sv]
// Self-checking testbench for the ISO media box walker: directed files, then random box chains.
`timescale 1ns / 1ps

module tb_iso_media_box_walker_top;
  import iso_mbw_pkg::*;

  localparam int unsigned ITEMS_TARGET = 800;
  localparam int unsigned CALM_TAIL    = 150;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned N_DIRECTED   = 25;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic in_tlast = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic out_tuser;
  logic out_tlast;

  iso_media_box_walker_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  int unsigned cycle_count = 0;
  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Some tests failed");
    $finish;
  end

  // Walking state of the box chain as the testbench sees it.
  logic [63:0] walk_pos;
  logic [63:0] box_base;
  logic [4:0]  hdr_seen;
  logic [63:0] size_acc;
  logic [31:0] type_acc;
  logic [63:0] next_box;
  status_t     stop_code;
  logic        walk_stopped;

  result_t pending_reports[$];
  int      fail_count = 0;
  int unsigned bytes_sent = 0;
  bit      tail_calm = 1'b0;
  bit      sender_gaps = 1'b0;
  logic [7:0] file_bytes[$];

  function automatic logic [63:0] offset_sum(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? '1 : s[63:0];
  endfunction

  task automatic clear_walk();
    walk_pos     = '0;
    box_base     = '0;
    hdr_seen     = '0;
    size_acc     = '0;
    type_acc     = '0;
    next_box     = '0;
    stop_code    = ST_OK;
    walk_stopped = 1'b0;
  endtask

  task automatic halt_walk(input status_t code);
    walk_stopped = 1'b1;
    stop_code    = code;
    hdr_seen     = '0;
  endtask

  task automatic push_report(input kind_t k, input status_t s, input logic [63:0] off,
                             input logic [63:0] len, input logic [31:0] typ,
                             input logic [63:0] endpos, input logic lst);
    pending_reports.push_back('{kind: k, status: s, offset: off, length: len, btype: typ,
                                expected: endpos, last: lst});
  endtask

  // Advances the walk by one accepted byte and queues the reports it causes.
  task automatic walk_byte(input logic [7:0] b, input logic eof);
    logic [63:0] pos;
    logic [63:0] file_len;
    logic [4:0]  idx;
    logic [4:0]  hdr_len;
    pos     = walk_pos;
    hdr_len = '0;
    if (!walk_stopped && (hdr_seen != 0 || pos == next_box)) begin
      idx = hdr_seen;
      if (idx == 0) begin
        box_base = pos;
        size_acc = '0;
        type_acc = '0;
      end
      if (idx < 4) size_acc = {size_acc[55:0], b};
      else if (idx < HDR_SHORT) type_acc = {type_acc[23:0], b};
      else if (idx == HDR_SHORT) size_acc = {56'd0, b};
      else size_acc = {size_acc[55:0], b};
      idx = idx + 5'd1;
      hdr_seen = idx;
      if (idx == HDR_SHORT) begin
        if (size_acc == 0) halt_walk(ST_ZERO_SIZE);
        else if (size_acc != SIZE_LARGE) hdr_len = HDR_SHORT;
      end else if (idx >= HDR_LONG) begin
        hdr_len = HDR_LONG;
      end
      if (hdr_len != 0) begin
        hdr_seen = '0;
        if (size_acc < {59'd0, hdr_len}) begin
          halt_walk(ST_MALFORMED);
        end else begin
          push_report(KIND_BOX, ST_OK, box_base, size_acc, type_acc, '0, 1'b0);
          next_box = offset_sum(box_base, size_acc);
        end
      end
    end
    if (eof) begin
      file_len = offset_sum(pos, 64'd1);
      if (walk_stopped)
        push_report(KIND_FINAL, stop_code, '0, '0, '0, '0, 1'b1);
      else if (hdr_seen >= HDR_SHORT)
        // The file ended inside the 64-bit size of a large header.
        push_report(KIND_FINAL, ST_INCOMPLETE, '0, '0, '0, next_box, 1'b1);
      else if (hdr_seen != 0)
        // A short tail inside a plain header still counts as a clean end.
        push_report(KIND_FINAL, ST_OK, '0, '0, '0, next_box, 1'b1);
      else
        push_report(KIND_FINAL, (next_box > file_len) ? ST_INCOMPLETE : ST_OK,
                    '0, '0, '0, next_box, 1'b1);
      clear_walk();
    end else begin
      walk_pos = offset_sum(pos, 64'd1);
    end
  endtask

  // Presents one byte, waits for the request to be taken, then updates the walk.
  task automatic send_byte(input logic [7:0] b, input logic eof);
    if (sender_gaps && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= eof;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    walk_byte(b, eof);
    bytes_sent++;
    @(negedge clk);
  endtask

  // Holds the sender off until every queued report has come out.
  task automatic wait_for_drain();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (pending_reports.size() != 0);
  endtask

  task automatic put_be(input logic [63:0] v, input int n);
    for (int i = n - 1; i >= 0; i--) file_bytes.push_back(v[8*i +: 8]);
  endtask

  task automatic put_noise(input int unsigned n);
    repeat (n) file_bytes.push_back(8'($urandom_range(0, 255)));
  endtask

  // Builds one file: mostly a chain of valid boxes, closed by one of the ways a file can end.
  task automatic build_file();
    int unsigned nbox;
    int unsigned sz;
    int unsigned ending;
    logic [63:0] big;
    file_bytes.delete();
    if ($urandom_range(0, 9) == 0) begin
      put_noise($urandom_range(1, 40));
    end else begin
      nbox = $urandom_range(0, 4);
      repeat (nbox) begin
        if ($urandom_range(0, 3) == 0) begin
          sz = $urandom_range(16, 40);
          put_be(SIZE_LARGE, 4);
          put_be(64'($urandom()), 4);
          put_be(64'(sz), 8);
          put_noise(sz - 16);
        end else begin
          sz = $urandom_range(8, 40);
          put_be(64'(sz), 4);
          put_be(64'($urandom()), 4);
          put_noise(sz - 8);
        end
      end
      ending = $urandom_range(0, 7);
      case (ending)
        0: begin
          // Ends exactly on a box boundary.
        end
        1: begin
          sz = $urandom_range(9, 64);
          put_be(64'(sz), 4);
          put_be(64'($urandom()), 4);
          put_noise($urandom_range(0, sz - 9));
        end
        2: put_noise($urandom_range(1, 7));
        3: begin
          put_be(SIZE_LARGE, 4);
          put_be(64'($urandom()), 4);
          put_noise($urandom_range(0, 7));
        end
        4: begin
          put_be(64'd0, 4);
          put_be(64'($urandom()), 4);
          put_noise($urandom_range(0, 6));
        end
        5: begin
          put_be(64'($urandom_range(2, 7)), 4);
          put_be(64'($urandom()), 4);
          put_noise($urandom_range(0, 6));
        end
        6: begin
          put_be(SIZE_LARGE, 4);
          put_be(64'($urandom()), 4);
          put_be(64'($urandom_range(0, 15)), 8);
          put_noise($urandom_range(0, 4));
        end
        default: begin
          // Huge sizes; the large form lands near the top so the box end may saturate.
          if ($urandom_range(0, 1) == 0) begin
            put_be(64'($urandom() | 32'h8000_0000), 4);
            put_be(64'($urandom()), 4);
          end else begin
            big = 64'hFFFF_FFFF_FFFF_FF00 | 64'($urandom_range(0, 255));
            put_be(SIZE_LARGE, 4);
            put_be(64'($urandom()), 4);
            put_be(big, 8);
          end
          put_noise($urandom_range(0, 8));
        end
      endcase
    end
    if (file_bytes.size() == 0) put_noise(1);
  endtask

  // Directed files. Rows marked pinned carry a final status that is plain to see;
  // the box report of the overrun file comes from the walk above.
  typedef struct packed {
    logic [7:0]  value;
    logic        eof;
    logic        pinned;
    status_t     fstat;
    logic [63:0] fsize;
  } stim_row_t;

  stim_row_t directed_rows [N_DIRECTED] = '{
    // Size 7 is below the header: malformed, type bytes at their maximum.
    '{8'h00, 1'b0, 1'b0, ST_OK, 64'd0},
    '{8'h00, 1'b0, 1'b0, ST_OK, 64'd0},
    '{8'h00, 1'b0, 1'b0, ST_OK, 64'd0},
    '{8'h07, 1'b0, 1'b0, ST_OK, 64'd0},
    '{8'hFF, 1'b0, 1'b0, ST_OK, 64'd0},
    '{8'hFF, 1'b0, 1'b0, ST_OK, 64'd0},
    '{8'hFF, 1'b0, 1'b0, ST_OK, 64'd0},
    '{8'hFF, 1'b1, 1'b1, ST_MALFORMED, 64'd0},
    // Size 0: the walk stops with a zero size box.
    '{8'h00, 1'b0, 1'b0, ST_OK, 64'd0},
    '{8'h00, 1'b0, 1'b0, ST_OK, 64'd0},
    '{8'h00, 1'b0, 1'b0, ST_OK, 64'd0},
    '{8'h00, 1'b0, 1'b0, ST_OK, 64'd0},
    '{8'h73, 1'b0, 1'b0, ST_OK, 64'd0},
    '{8'h6B, 1'b0, 1'b0, ST_OK, 64'd0},
    '{8'h69, 1'b0, 1'b0, ST_OK, 64'd0},
    '{8'h70, 1'b1, 1'b1, ST_ZERO_SIZE, 64'd0},
    // A 9-byte box in an 8-byte file: reported, then the file overruns.
    '{8'h00, 1'b0, 1'b0, ST_OK, 64'd0},
    '{8'h00, 1'b0, 1'b0, ST_OK, 64'd0},
    '{8'h00, 1'b0, 1'b0, ST_OK, 64'd0},
    '{8'h09, 1'b0, 1'b0, ST_OK, 64'd0},
    '{8'h66, 1'b0, 1'b0, ST_OK, 64'd0},
    '{8'h72, 1'b0, 1'b0, ST_OK, 64'd0},
    '{8'h65, 1'b0, 1'b0, ST_OK, 64'd0},
    '{8'h65, 1'b1, 1'b1, ST_INCOMPLETE, 64'd9},
    // A one-byte file ends inside a plain header, which is still clean.
    '{8'h00, 1'b1, 1'b1, ST_OK, 64'd0}
  };

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endtask

  result_t want_report;

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_reports.size() == 0) begin
        $error("result with no report outstanding: kind %0b, status %0d",
               out_tuser, out_tdata[1:0]);
        fail_count++;
      end else begin
        want_report = pending_reports.pop_front();
        check_field("report_kind", 64'(want_report.kind), 64'(out_tuser));
        check_field("status", 64'(want_report.status), 64'(out_tdata[1:0]));
        check_field("box_offset", want_report.offset, out_tdata[65:2]);
        check_field("box_length", want_report.length, out_tdata[129:66]);
        check_field("box_fourcc", 64'(want_report.btype), 64'(out_tdata[161:130]));
        check_field("expected_size", want_report.expected, out_tdata[225:162]);
        check_field("last_result", 64'(want_report.last), 64'(out_tlast));
      end
    end
  end

  // Result side: ready in stretches, stalled in short bursts, steady near the end.
  initial begin
    wait (rst_n);
    forever begin
      if (tail_calm || $urandom_range(0, 2) != 0) begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(negedge clk);
      end else begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(negedge clk);
      end
    end
  end

  initial begin
    bit paused_mid;
    paused_mid = 1'b0;
    clear_walk();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    sender_gaps = 1'b1;
    for (int r = 0; r < N_DIRECTED; r++) begin
      send_byte(directed_rows[r].value, directed_rows[r].eof);
      if (directed_rows[r].pinned) begin
        void'(pending_reports.pop_back());
        push_report(KIND_FINAL, directed_rows[r].fstat, '0, '0, '0,
                    directed_rows[r].fsize, 1'b1);
      end
    end
    wait_for_drain();

    while (bytes_sent < ITEMS_TARGET + N_DIRECTED) begin
      tail_calm   = (bytes_sent + CALM_TAIL >= ITEMS_TARGET + N_DIRECTED);
      sender_gaps = !tail_calm && $urandom_range(0, 2) != 0;
      build_file();
      foreach (file_bytes[k]) send_byte(file_bytes[k], k == file_bytes.size() - 1);
      if (!paused_mid && bytes_sent >= ITEMS_TARGET / 2) begin
        paused_mid = 1'b1;
        wait_for_drain();
      end
    end

    in_tvalid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_reports.size() != 0) begin
      $error("%0d reports never arrived", pending_reports.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
